// File: design/ptl_pkg.sv
// shared constants and types for the pixel threshold packer and luma converter
package ptl_pkg;

    localparam int MAX_WIDTH_DEF = 4096;

    localparam int PIX_W   = 8;
    localparam int MAXV_W  = 8;
    localparam int WIDTH_W = 13;
    localparam int CFG_W   = 13;
    localparam int IDX_W   = 2;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_PIXEL_MODE  = 2'd0;
    localparam logic [IDX_W-1:0] REG_MAX_VALUE   = 2'd1;
    localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH = 2'd2;

    // pixel modes
    localparam logic MODE_BILEVEL = 1'b0;
    localparam logic MODE_LUMA    = 1'b1;

    localparam logic [MAXV_W-1:0]  MAX_VALUE_RST   = 8'd255;
    localparam logic [WIDTH_W-1:0] IMAGE_WIDTH_RST = 13'd1;

    // bt601 weights, 16 fraction bits, sum is exactly 65536
    localparam int COEF_W = 17;
    localparam logic [COEF_W-1:0] LUMA_R = 17'd19595;
    localparam logic [COEF_W-1:0] LUMA_G = 17'd38470;
    localparam logic [COEF_W-1:0] LUMA_B = 17'd7471;
    localparam int LUMA_SUM_W = COEF_W + PIX_W;

    typedef struct packed {
        logic              emit;
        logic              row_end;
        logic [PIX_W-1:0]  pack_byte;
        logic [2:0]        bit_count;
    } t_pack_res;

endpackage

// File: design/ptl_luma.sv
// rgb to gray luma byte, fixed point bt601 weights
module ptl_luma (
    input  logic [ptl_pkg::PIX_W-1:0] i_red,
    input  logic [ptl_pkg::PIX_W-1:0] i_green,
    input  logic [ptl_pkg::PIX_W-1:0] i_blue,
    output logic [ptl_pkg::PIX_W-1:0] o_luma
);

    logic [ptl_pkg::LUMA_SUM_W-1:0] prod_r;
    logic [ptl_pkg::LUMA_SUM_W-1:0] prod_g;
    logic [ptl_pkg::LUMA_SUM_W-1:0] prod_b;
    logic [ptl_pkg::LUMA_SUM_W-1:0] sum;

    assign prod_r = ptl_pkg::LUMA_SUM_W'(ptl_pkg::LUMA_R) * ptl_pkg::LUMA_SUM_W'(i_red);
    assign prod_g = ptl_pkg::LUMA_SUM_W'(ptl_pkg::LUMA_G) * ptl_pkg::LUMA_SUM_W'(i_green);
    assign prod_b = ptl_pkg::LUMA_SUM_W'(ptl_pkg::LUMA_B) * ptl_pkg::LUMA_SUM_W'(i_blue);
    assign sum    = prod_r + prod_g + prod_b;

    // weights sum to one, so the integer part never exceeds 255
    assign o_luma = sum[23:16];

endmodule

// File: design/ptl_packer.sv
// column tracking, threshold and msb-first bit packing with row end padding
module ptl_packer #(
    parameter int MAX_WIDTH = ptl_pkg::MAX_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_advance,
    input  logic                         i_mode,
    input  logic [ptl_pkg::PIX_W-1:0]    i_gray,
    input  logic [ptl_pkg::MAXV_W-1:0]   i_max_value,
    input  logic [ptl_pkg::WIDTH_W-1:0]  i_image_width,
    output ptl_pkg::t_pack_res           o_res
);

    localparam int COLW = $clog2(MAX_WIDTH);
    localparam int CW   = $clog2(MAX_WIDTH + 1);
    localparam int EW   = (CW > ptl_pkg::WIDTH_W) ? CW : ptl_pkg::WIDTH_W;

    logic [COLW-1:0]              r_column;
    logic [COLW-1:0]              n_column;
    logic [ptl_pkg::PIX_W-1:0]    r_pack_bits;
    logic [ptl_pkg::PIX_W-1:0]    n_pack_bits;
    logic [2:0]                   r_bit_count;
    logic [2:0]                   n_bit_count;

    logic [EW-1:0]                eff_width;
    logic [EW-1:0]                last_col;
    logic                         last;
    logic [ptl_pkg::MAXV_W:0]     max_plus;
    logic [ptl_pkg::MAXV_W-1:0]   threshold;
    logic                         pix_bit;
    logic [ptl_pkg::PIX_W-1:0]    shifted;
    logic [2:0]                   pad;
    logic [ptl_pkg::PIX_W-1:0]    padded;
    logic                         full;

    always_comb begin
        eff_width = EW'(i_image_width);
        if (eff_width == '0) begin
            eff_width = EW'(1);
        end
        if (eff_width > EW'(MAX_WIDTH)) begin
            eff_width = EW'(MAX_WIDTH);
        end
    end

    // a column left beyond a narrowed row also closes the row
    assign last_col = eff_width - EW'(1);
    assign last     = (EW'(r_column) >= last_col);

    assign max_plus  = {1'b0, i_max_value} + 9'd1;
    assign threshold = max_plus[ptl_pkg::MAXV_W:1];
    assign pix_bit   = !(i_gray > threshold);
    assign shifted   = {r_pack_bits[ptl_pkg::PIX_W-2:0], pix_bit};
    assign full      = (r_bit_count == 3'd7);

    // fill the free low bits with ones at a row end
    assign pad    = 3'd7 - r_bit_count;
    assign padded = (shifted << pad) | ~(8'hFF << pad);

    always_comb begin
        o_res.emit      = (i_mode == ptl_pkg::MODE_LUMA) || last || full;
        o_res.row_end   = last;
        o_res.pack_byte = last ? padded : shifted;
        o_res.bit_count = r_bit_count;
    end

    always_comb begin
        n_column    = r_column;
        n_pack_bits = r_pack_bits;
        n_bit_count = r_bit_count;
        if (i_advance) begin
            n_column = last ? '0 : r_column + COLW'(1);
            if (i_mode == ptl_pkg::MODE_BILEVEL) begin
                if (last || full) begin
                    n_pack_bits = '0;
                    n_bit_count = '0;
                end else begin
                    n_pack_bits = shifted;
                    n_bit_count = r_bit_count + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column    <= '0;
            r_pack_bits <= '0;
            r_bit_count <= '0;
        end else begin
            r_column    <= n_column;
            r_pack_bits <= n_pack_bits;
            r_bit_count <= n_bit_count;
        end
    end

endmodule

// File: design/pixel_threshold_pack_and_luma.sv
// top level: input register, packer and luma logic, result register
//
//  channel  direction  handshake           payload
//  pixel    in         i_valid / o_ready   i_red_or_gray, i_green, i_blue
//  result   out        o_valid / i_ready   o_out_byte, o_row_end
//  config   in         i_cfg_we            i_cfg_index, i_cfg_data
//
// one pixel per clock while the result is not stalled; a pixel is held in the input
// register from its transaction until it advances, and an emitted byte then goes to the result register
// a bilevel pixel that neither fills a byte nor ends a row moves on without
// using the result register, so it never waits on a stalled output
// reset is synchronous and clears the column, the packing state and the
// configuration registers to bilevel mode, max value 255, width 1
// when both registers are full and the held pixel emits, o_ready follows i_ready
module pixel_threshold_pack_and_luma #(
    parameter int MAX_WIDTH = ptl_pkg::MAX_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [ptl_pkg::PIX_W-1:0]   i_red_or_gray,
    input  logic [ptl_pkg::PIX_W-1:0]   i_green,
    input  logic [ptl_pkg::PIX_W-1:0]   i_blue,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [ptl_pkg::PIX_W-1:0]   o_out_byte,
    output logic                        o_row_end,
    input  logic                        i_cfg_we,
    input  logic [ptl_pkg::IDX_W-1:0]   i_cfg_index,
    input  logic [ptl_pkg::CFG_W-1:0]   i_cfg_data
);

    logic                           r_mode;
    logic [ptl_pkg::MAXV_W-1:0]     r_max_value;
    logic [ptl_pkg::WIDTH_W-1:0]    r_image_width;

    logic                           r_in_valid;
    logic [ptl_pkg::PIX_W-1:0]      r_red;
    logic [ptl_pkg::PIX_W-1:0]      r_green;
    logic [ptl_pkg::PIX_W-1:0]      r_blue;

    logic                           r_out_valid;
    logic [ptl_pkg::PIX_W-1:0]      r_out_byte;
    logic                           r_row_end;

    ptl_pkg::t_pack_res             pack_res;
    logic [ptl_pkg::PIX_W-1:0]      luma;
    logic                           out_free;
    logic                           advance;
    logic                           load_out;

    assign out_free = !r_out_valid || i_ready;
    assign advance  = r_in_valid && (!pack_res.emit || out_free);
    assign load_out = advance && pack_res.emit;
    assign o_ready  = !r_in_valid || advance;

    ptl_packer #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_packer (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_advance     (advance),
        .i_mode        (r_mode),
        .i_gray        (r_red),
        .i_max_value   (r_max_value),
        .i_image_width (r_image_width),
        .o_res         (pack_res)
    );

    ptl_luma u_luma (
        .i_red   (r_red),
        .i_green (r_green),
        .i_blue  (r_blue),
        .o_luma  (luma)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= ptl_pkg::MODE_BILEVEL;
            r_max_value   <= ptl_pkg::MAX_VALUE_RST;
            r_image_width <= ptl_pkg::IMAGE_WIDTH_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ptl_pkg::REG_PIXEL_MODE:  r_mode        <= i_cfg_data[0];
                ptl_pkg::REG_MAX_VALUE:   r_max_value   <= i_cfg_data[ptl_pkg::MAXV_W-1:0];
                ptl_pkg::REG_IMAGE_WIDTH: r_image_width <= i_cfg_data[ptl_pkg::WIDTH_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_red   <= i_red_or_gray;
            r_green <= i_green;
            r_blue  <= i_blue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_byte <= (r_mode == ptl_pkg::MODE_LUMA) ? luma : pack_res.pack_byte;
            r_row_end  <= pack_res.row_end;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_out_byte = r_out_byte;
    assign o_row_end  = r_row_end;

    // a bilevel row end always leaves the packer empty
    a_row_end_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && pack_res.row_end && (r_mode == ptl_pkg::MODE_BILEVEL)
        |=> pack_res.bit_count == 3'd0)
        else $error("packer holds bits after a row end");

    // a new pixel is refused only while a held pixel waits on a stalled result
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> r_in_valid && r_out_valid && !i_ready)
        else $error("input refused without a stalled result");

    // every emitted byte shows up as a result on the next cycle
    a_emit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |=> o_valid)
        else $error("emitted byte not presented");

endmodule
